// ===== hw/rtl/crcu_pkg.sv =====
// shared types and constants of the catmull-rom curve upsampler
// no dependencies; compiled before every other file of the block

package crcu_pkg;

   localparam int STEPS_DEF  = 16;
   localparam int POINTS_DEF = 256;
   localparam int OUT_LIMIT  = 16;

   localparam int AHW   = 12;
   localparam int SPW   = 8;
   localparam int XW    = 16;
   localparam int YW    = 20;
   localparam int FRACW = 8;
   localparam int REGW  = 2;
   localparam int CSRDW = 12;

   localparam logic [AHW-1:0] MIN_HEIGHT_RST = 12'd252;
   localparam logic [AHW-1:0] MAX_HEIGHT_RST = 12'd684;
   localparam logic [SPW-1:0] X_SPACING_RST  = 8'd8;

   typedef enum logic [REGW-1:0] {
      REG_MIN_HEIGHT = 2'd0,
      REG_MAX_HEIGHT = 2'd1,
      REG_X_SPACING  = 2'd2
   } crcu_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_PT0,
      ST_PT1,
      ST_PT2,
      ST_DIV,
      ST_WAIT,
      ST_EMIT
   } crcu_state_type;

endpackage

// ===== hw/rtl/crcu_if.sv =====
// valid/ready channels of the curve upsampler: anchors in, points out, register writes
// depends on crcu_pkg

interface crcu_req_if import crcu_pkg::*; ();
   logic           valid;
   logic           ready;
   logic [AHW-1:0] anchor_height;
   logic           restart;

   modport source (output valid, anchor_height, restart, input ready);
   modport sink (input valid, anchor_height, restart, output ready);
endinterface

interface crcu_rsp_if import crcu_pkg::*; ();
   logic          valid;
   logic          ready;
   logic [XW-1:0] x_pos;
   logic [YW-1:0] y_height;
   logic          last;

   modport source (output valid, x_pos, y_height, last, input ready);
   modport sink (input valid, x_pos, y_height, last, output ready);
endinterface

interface crcu_csr_if import crcu_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [REGW-1:0]  reg_index;
   logic [CSRDW-1:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ===== hw/rtl/crcu_mac.sv =====
// shared multiply-add unit: res = a * b + c, registered, updated when en is high
// depends on crcu_pkg

module crcu_mac import crcu_pkg::*; #(
   parameter int AW = 32,
   parameter int BW = 8
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [AW-1:0] a,
   input  logic        [BW-1:0] b,
   input  logic signed [AW-1:0] c,
   output logic signed [AW-1:0] res
);

   logic signed [AW+BW:0] prod;
   logic signed [AW-1:0]  res_ff;
   logic signed [AW-1:0]  res_in;

   assign prod   = a * $signed({1'b0, b});
   assign res_in = $signed(prod[AW-1:0]) + c;
   assign res    = res_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

endmodule

// ===== hw/rtl/crcu_div.sv =====
// divider by a constant through reciprocal multiplication: quot = floor(nc * 256 / DIVISOR)
// registered estimate and correction; nc must stay below 4096 * DIVISOR; depends on crcu_pkg

module crcu_div import crcu_pkg::*; #(
   parameter int DIVISOR = 8192,
   parameter int NCW     = 25
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [NCW-1:0] nc,
   output logic           done,
   output logic [YW-1:0]  quot
);

   localparam int     NUMW  = NCW + FRACW;
   localparam longint RECIP = (longint'(1) << NUMW) / longint'(DIVISOR);
   localparam int     RW    = $clog2(RECIP + 1);
   localparam int     PRW   = NCW + RW;

   localparam logic [RW-1:0]   RECIP_V = RW'(RECIP);
   localparam logic [NUMW-1:0] DIV_V   = NUMW'(DIVISOR);
   localparam logic [YW-1:0]   Q_ONE   = YW'(1);

   logic            est_vld_ff, est_vld_in;
   logic            done_ff, done_in;
   logic [PRW-1:0]  prod_ff, prod_in;
   logic [NUMW-1:0] num_ff, num_in;
   logic [YW-1:0]   q_ff, q_in;
   logic [YW-1:0]   q_est;
   logic [NUMW-1:0] q_back;
   logic [NUMW-1:0] rem;

   // first step: quotient estimate, low by at most one
   assign prod_in    = PRW'(nc) * PRW'(RECIP_V);
   assign num_in     = {nc, {FRACW{1'b0}}};
   assign est_vld_in = start;

   // second step: one correction step
   assign q_est   = prod_ff[NCW +: YW];
   assign q_back  = NUMW'(q_est) * DIV_V;
   assign rem     = num_ff - q_back;
   assign q_in    = (rem >= DIV_V) ? q_est + Q_ONE : q_est;
   assign done_in = est_vld_ff;

   assign done = done_ff;
   assign quot = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         est_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         est_vld_ff <= est_vld_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
         num_ff  <= num_in;
      end
      if (est_vld_ff) begin
         q_ff <= q_in;
      end
   end

endmodule

// ===== hw/rtl/catmull_rom_curve_upsampler.sv =====
// catmull-rom curve upsampler top level: anchor window, sequencer, clamp, output register
// depends on crcu_pkg, crcu_if, crcu_mac, crcu_div
//
//   channel  | dir | transfer carries
//   ---------+-----+----------------------------------------
//   req_bus  | in  | anchor_height, restart
//   rsp_bus  | out | x_pos, y_height, last
//   csr_bus  | in  | reg_index, wr_data (min, max, spacing)
//
// an anchor that gives no points is only taken into the window; one that gives
// points takes six multiplies on the shared multiply-add unit per anchor, then
// for each of up to min(STEPS, 16) points three horner multiplies, one step that
// starts the divider, a wait on the reciprocal divider and one emit step
// synchronous reset; the next point is computed while a finished one waits in
// the output register, a stalled output holds the sequencer at its emit step

module catmull_rom_curve_upsampler import crcu_pkg::*; #(
   parameter int STEPS  = STEPS_DEF,
   parameter int POINTS = POINTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   crcu_req_if.sink   req_bus,
   crcu_rsp_if.source rsp_bus,
   crcu_csr_if.sink   csr_bus
);

   localparam int SB       = $clog2(STEPS + 1);
   localparam int AW       = 17 + 3 * SB;
   localparam int BW       = (SB > SPW) ? SB : SPW;
   localparam int PW       = $clog2(POINTS + 1);
   localparam int LIM      = (STEPS < OUT_LIMIT) ? STEPS : OUT_LIMIT;
   localparam int DIVISOR  = 2 * STEPS * STEPS * STEPS;
   localparam longint NSAT_L = longint'(4096) * longint'(DIVISOR) - 1;
   localparam int NCW      = $clog2(NSAT_L + 1);

   localparam logic signed [AW-1:0] NSAT     = AW'(NSAT_L);
   localparam logic        [BW-1:0] STEPS_B  = BW'(STEPS);
   localparam logic        [SB-1:0] K_LAST   = SB'(LIM - 1);
   localparam logic        [PW-1:0] PIDX_END = PW'(POINTS);
   localparam logic        [PW-1:0] PIDX_LST = PW'(POINTS - 1);
   localparam logic        [2:0]    PRE_LAST = 3'd6;
   localparam logic        [1:0]    HELD_ALL = 2'd3;

   crcu_state_type state_ff, state_in;

   logic [AHW-1:0] min_h_ff, max_h_ff;
   logic [SPW-1:0] space_ff;
   logic [AHW-1:0] win_ff [3];
   logic [1:0]     held_ff;
   logic [PW-1:0]  pidx_ff;
   logic [SB-1:0]  k_ff;
   logic [2:0]     pre_cnt_ff;
   logic [AHW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [AW-1:0] c2s_ff, c1s2_ff, p1s3_ff;

   logic          rsp_valid_ff;
   logic [XW-1:0] rsp_x_ff;
   logic [YW-1:0] rsp_y_ff;
   logic          rsp_last_ff;

   logic req_fire, csr_fire, go, last_pt, out_load;
   logic req_ready;

   logic signed [AW-1:0] p0_s, p1_s, p2_s, p3_s, d12;
   logic signed [AW-1:0] c1, c2, c3;

   logic                 mac_en;
   logic signed [AW-1:0] mac_a, mac_c, mac_res;
   logic        [BW-1:0] mac_b;

   logic           div_start, div_done;
   logic [NCW-1:0] div_nc;
   logic [YW-1:0]  div_q;
   logic [YW-1:0]  lo_y, hi_y, y_lo, y_out;

   assign req_fire = req_bus.valid && req_ready;
   assign csr_fire = csr_bus.valid;
   assign go       = !req_bus.restart && (held_ff == HELD_ALL) && (pidx_ff < PIDX_END);
   assign last_pt  = (k_ff == K_LAST) || (pidx_ff == PIDX_LST);

   assign req_bus.ready    = req_ready;
   assign csr_bus.ready    = 1'b1;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.x_pos    = rsp_x_ff;
   assign rsp_bus.y_height = rsp_y_ff;
   assign rsp_bus.last     = rsp_last_ff;

   // segment coefficients
   assign p0_s = $signed(AW'(p0_ff));
   assign p1_s = $signed(AW'(p1_ff));
   assign p2_s = $signed(AW'(p2_ff));
   assign p3_s = $signed(AW'(p3_ff));
   assign d12  = p1_s - p2_s;
   assign c1   = p2_s - p0_s;
   assign c2   = (p0_s <<< 1) - (p1_s <<< 2) - p1_s + (p2_s <<< 2) - p3_s;
   assign c3   = (d12 <<< 1) + d12 + p3_s - p0_s;

   // clamp to the divider range, then to the height limits
   assign div_nc = (mac_res < 0) ? '0 : ((mac_res > NSAT) ? NCW'(NSAT) : NCW'(mac_res));
   assign lo_y   = {min_h_ff, {FRACW{1'b0}}};
   assign hi_y   = {max_h_ff, {FRACW{1'b0}}};
   assign y_lo   = (div_q < lo_y) ? lo_y : div_q;
   assign y_out  = (y_lo > hi_y) ? hi_y : y_lo;

   crcu_mac #(
      .AW (AW),
      .BW (BW)
   ) u_mac (
      .clock (clock),
      .en    (mac_en),
      .a     (mac_a),
      .b     (mac_b),
      .c     (mac_c),
      .res   (mac_res)
   );

   crcu_div #(
      .DIVISOR (DIVISOR),
      .NCW     (NCW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .nc    (div_nc),
      .done  (div_done),
      .quot  (div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && go) state_in = ST_PRE;
         end
         ST_PRE: begin
            if (pre_cnt_ff == PRE_LAST) state_in = ST_PT0;
         end
         ST_PT0: state_in = ST_PT1;
         ST_PT1: state_in = ST_PT2;
         ST_PT2: state_in = ST_DIV;
         ST_DIV: state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_load) state_in = last_pt ? ST_IDLE : ST_PT0;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      mac_en    = 1'b0;
      mac_a     = '0;
      mac_b     = STEPS_B;
      mac_c     = '0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_PRE: begin
            mac_en = (pre_cnt_ff != PRE_LAST);
            unique case (pre_cnt_ff)
               3'd0:    mac_a = c2;
               3'd1:    mac_a = c1;
               3'd3:    mac_a = p1_s <<< 1;
               default: mac_a = mac_res;
            endcase
         end
         ST_PT0: begin
            mac_en = 1'b1;
            mac_a  = c3;
            mac_b  = BW'(k_ff);
            mac_c  = c2s_ff;
         end
         ST_PT1: begin
            mac_en = 1'b1;
            mac_a  = mac_res;
            mac_b  = BW'(k_ff);
            mac_c  = c1s2_ff;
         end
         ST_PT2: begin
            mac_en = 1'b1;
            mac_a  = mac_res;
            mac_b  = BW'(k_ff);
            mac_c  = p1s3_ff;
         end
         ST_DIV: begin
            div_start = 1'b1;
            mac_en    = 1'b1;
            mac_a     = $signed(AW'(pidx_ff));
            mac_b     = BW'(space_ff);
         end
         ST_WAIT: ;
         ST_EMIT: out_load = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_h_ff     <= MIN_HEIGHT_RST;
         max_h_ff     <= MAX_HEIGHT_RST;
         space_ff     <= X_SPACING_RST;
         win_ff[0]    <= '0;
         win_ff[1]    <= '0;
         win_ff[2]    <= '0;
         held_ff      <= '0;
         pidx_ff      <= '0;
         k_ff         <= '0;
         pre_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_fire) begin
            unique case (csr_bus.reg_index)
               REG_MIN_HEIGHT: min_h_ff <= csr_bus.wr_data;
               REG_MAX_HEIGHT: max_h_ff <= csr_bus.wr_data;
               REG_X_SPACING:  space_ff <= csr_bus.wr_data[SPW-1:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            win_ff[0]  <= req_bus.restart ? '0 : win_ff[1];
            win_ff[1]  <= req_bus.restart ? '0 : win_ff[2];
            win_ff[2]  <= req_bus.anchor_height;
            k_ff       <= '0;
            pre_cnt_ff <= '0;
            if (req_bus.restart) begin
               held_ff <= 2'd1;
               pidx_ff <= '0;
            end else if (held_ff != HELD_ALL) begin
               held_ff <= held_ff + 2'd1;
            end
         end
         if (state_ff == ST_PRE) pre_cnt_ff <= pre_cnt_ff + 3'd1;
         if (out_load) begin
            k_ff    <= k_ff + SB'(1);
            pidx_ff <= pidx_ff + PW'(1);
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working window, precomputed terms and output payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         p0_ff <= win_ff[0];
         p1_ff <= win_ff[1];
         p2_ff <= win_ff[2];
         p3_ff <= req_bus.anchor_height;
      end
      if (state_ff == ST_PRE) begin
         if (pre_cnt_ff == 3'd1) c2s_ff  <= mac_res;
         if (pre_cnt_ff == 3'd3) c1s2_ff <= mac_res;
         if (pre_cnt_ff == PRE_LAST) p1s3_ff <= mac_res;
      end
      if (out_load) begin
         rsp_x_ff    <= mac_res[XW-1:0];
         rsp_y_ff    <= y_out;
         rsp_last_ff <= last_pt;
      end
   end

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_WAIT)
      else $error("divider finished outside its wait step");

   a_pidx_budget: assert property (@(posedge clock) disable iff (reset)
      pidx_ff <= PIDX_END)
      else $error("point index ran past the point budget");

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> k_ff <= K_LAST)
      else $error("point step beyond the per-anchor limit");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff && (state_ff == ST_IDLE || state_ff == ST_PT0))
      else $error("loaded point not presented or sequencer off track");

endmodule

// ===== sim/catmull_rom_curve_upsampler_test.sv =====
// self-checking testbench of the catmull-rom curve upsampler: directed anchors, then random curves
// depends on crcu_pkg, crcu_if and the catmull_rom_curve_upsampler rtl

module catmull_rom_curve_upsampler_test;
   import crcu_pkg::*;

   localparam int ANCHOR_ROWS      = 25;
   localparam int NUM_PHASES       = 6;
   localparam int ITEMS_PER_PHASE  = 26;
   localparam int SETTLE_CYCLES    = 500;
   localparam int HOLD_OFF_CYCLES  = 1500;
   localparam int WATCHDOG_CYCLES  = 20000;
   localparam int REPORT_LIMIT     = 10;

   localparam logic [REGW-1:0] REG_UNUSED = 2'd3;
   localparam logic [YW-1:0]   Y_FLOOR    = {MIN_HEIGHT_RST, {FRACW{1'b0}}};
   localparam logic [YW-1:0]   Y_CEILING  = {MAX_HEIGHT_RST, {FRACW{1'b0}}};

   typedef struct {
      logic [XW-1:0] x_pos;
      logic [YW-1:0] y_height;
      logic          last;
   } curve_point_type;

   typedef struct {
      logic [AHW-1:0] height;
      logic           restart;
      logic           y_known;
      logic [YW-1:0]  y_height;
   } anchor_row_type;

   logic clock;
   logic reset;

   crcu_req_if req_bus();
   crcu_rsp_if rsp_bus();
   crcu_csr_if csr_bus();

   catmull_rom_curve_upsampler u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // register mirror and curve state
   logic [AHW-1:0] cfg_min     = MIN_HEIGHT_RST;
   logic [AHW-1:0] cfg_max     = MAX_HEIGHT_RST;
   logic [SPW-1:0] cfg_spacing = X_SPACING_RST;
   logic [AHW-1:0] window_h [3] = '{default: '0};
   logic [1:0]     held_count  = '0;
   logic [8:0]     point_count = '0;

   curve_point_type expected_points [$];
   int              mismatch_count = 0;
   bit              quiet          = 1'b0;
   bit              hold_off_req   = 1'b0;
   int              curve_left     = 0;
   int              walk_height    = 2048;

   anchor_row_type anchor_table [ANCHOR_ROWS] = '{
      '{12'd0,    1'b1, 1'b0, '0},
      '{12'd0,    1'b0, 1'b0, '0},
      '{12'd0,    1'b0, 1'b0, '0},
      '{12'd0,    1'b0, 1'b1, Y_FLOOR},     // flat at zero, clamped to the floor
      '{12'd4095, 1'b0, 1'b0, '0},
      '{12'd4095, 1'b0, 1'b0, '0},
      '{12'd4095, 1'b0, 1'b0, '0},
      '{12'd4095, 1'b0, 1'b1, Y_CEILING},   // flat at full scale, clamped to the ceiling
      '{12'd0,    1'b0, 1'b0, '0},
      '{12'd2048, 1'b0, 1'b0, '0},
      '{12'd1,    1'b0, 1'b0, '0},
      '{12'd4094, 1'b0, 1'b0, '0},
      '{12'd2730, 1'b0, 1'b0, '0},
      '{12'd1365, 1'b0, 1'b0, '0},
      '{12'd4095, 1'b0, 1'b0, '0},
      '{12'd0,    1'b0, 1'b0, '0},
      '{12'd684,  1'b0, 1'b0, '0},
      '{12'd252,  1'b0, 1'b0, '0},
      '{12'd3000, 1'b0, 1'b0, '0},
      '{12'd3333, 1'b0, 1'b0, '0},          // point budget spent
      '{12'd17,   1'b0, 1'b0, '0},
      '{12'd3000, 1'b1, 1'b0, '0},          // restart with a full window
      '{12'd500,  1'b0, 1'b0, '0},
      '{12'd100,  1'b1, 1'b0, '0},          // restart while filling
      '{12'd4095, 1'b0, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 16);
      return $urandom_range(40, 150);
   endfunction

   function automatic void predict_points(input logic [AHW-1:0] a, input logic rs,
                                          input logic y_known, input logic [YW-1:0] y_fixed);
      longint          p0, p1, p2, p3, s, d, lo, hi, num, k;
      int unsigned     xprod;
      int              n;
      curve_point_type pt;
      if (rs) begin
         window_h    = '{default: '0};
         held_count  = '0;
         point_count = '0;
      end
      if (held_count == 2'd3) begin
         s  = STEPS_DEF;
         d  = 2 * s * s * s;
         lo = cfg_min;
         lo = lo * d;
         hi = cfg_max;
         hi = hi * d;
         p0 = window_h[0];
         p1 = window_h[1];
         p2 = window_h[2];
         p3 = a;
         n  = 0;
         for (k = 0; k < s && n < OUT_LIMIT && point_count < POINTS_DEF; k++) begin
            num = 2 * p1 * s * s * s
                + (p2 - p0) * k * s * s
                + (2 * p0 - 5 * p1 + 4 * p2 - p3) * k * k * s
                + (-p0 + 3 * p1 - 3 * p2 + p3) * k * k * k;
            if (num < lo)
               num = lo;
            if (num > hi)
               num = hi;
            num = (num * 256) / d;
            xprod = point_count * cfg_spacing;
            pt.x_pos    = xprod[XW-1:0];
            pt.y_height = y_known ? y_fixed : num[YW-1:0];
            pt.last     = 1'b0;
            expected_points.push_back(pt);
            point_count = point_count + 9'd1;
            n++;
         end
         if (n > 0)
            expected_points[expected_points.size() - 1].last = 1'b1;
      end else begin
         held_count = held_count + 2'd1;
      end
      window_h[0] = window_h[1];
      window_h[1] = window_h[2];
      window_h[2] = a;
   endfunction

   task automatic send_anchor(input logic [AHW-1:0] a, input logic rs,
                              input logic y_known, input logic [YW-1:0] y_fixed);
      int unsigned gap;
      req_bus.valid         <= 1'b1;
      req_bus.anchor_height <= a;
      req_bus.restart       <= rs;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_points(a, rs, y_known, y_fixed);
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // mostly smooth curves behind a restart, some jumps, extremes and stray restarts
   task automatic send_random_anchor();
      logic        rs;
      int          h;
      int unsigned pick;
      rs = 1'b0;
      if (curve_left <= 0) begin
         rs = 1'b1;
         curve_left = ($urandom_range(0, 4) == 0) ? $urandom_range(18, 22)
                                                  : $urandom_range(4, 12);
      end else if ($urandom_range(0, 29) == 0) begin
         rs = 1'b1;
      end
      curve_left--;
      pick = $urandom_range(0, 19);
      if (pick < 3)
         h = $urandom_range(0, 4095);
      else if (pick == 3)
         h = 0;
      else if (pick == 4)
         h = 4095;
      else
         h = walk_height + int'($urandom_range(0, 400)) - 200;
      if (h < 0)
         h = 0;
      if (h > 4095)
         h = 4095;
      walk_height = h;
      send_anchor(h[AHW-1:0], rs, 1'b0, '0);
   endtask

   task automatic write_reg(input logic [REGW-1:0] idx, input logic [CSRDW-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wr_data   <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         REG_MIN_HEIGHT: cfg_min     = data[AHW-1:0];
         REG_MAX_HEIGHT: cfg_max     = data[AHW-1:0];
         REG_X_SPACING:  cfg_spacing = data[SPW-1:0];
         default: ;
      endcase
   endtask

   task automatic drain_points();
      req_bus.valid <= 1'b0;
      while (expected_points.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver with random stalls and one long hold-off on request
   initial begin : receiver
      int unsigned stall;
      stall = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : point_check
      curve_point_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected point: x=%0d y=%0d last=%0b",
                        rsp_bus.x_pos, rsp_bus.y_height, rsp_bus.last);
         end else begin
            want = expected_points.pop_front();
            if (want.x_pos !== rsp_bus.x_pos || want.y_height !== rsp_bus.y_height ||
                want.last !== rsp_bus.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"point mismatch: expected x=%0d y=%0d last=%0b, ",
                            "got x=%0d y=%0d last=%0b"},
                           want.x_pos, want.y_height, want.last,
                           rsp_bus.x_pos, rsp_bus.y_height, rsp_bus.last);
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if (reset === 1'b1 ||
             (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no transfer in %0d cycles", WATCHDOG_CYCLES);
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      int unsigned p, i;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.anchor_height <= '0;
      req_bus.restart       <= 1'b0;
      csr_bus.valid         <= 1'b0;
      csr_bus.reg_index     <= REG_MIN_HEIGHT;
      csr_bus.wr_data       <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (anchor_table[r])
         send_anchor(anchor_table[r].height, anchor_table[r].restart,
                     anchor_table[r].y_known, anchor_table[r].y_height);

      for (p = 0; p < NUM_PHASES; p++) begin
         drain_points();
         quiet = (p == 0) || (p == 3);
         case (p)
            0: begin
               write_reg(REG_MIN_HEIGHT, 12'd0);
               write_reg(REG_MAX_HEIGHT, 12'd4095);
               write_reg(REG_X_SPACING, 12'd255);
            end
            1: begin
               // inverted clamps
               write_reg(REG_MIN_HEIGHT, 12'd4095);
               write_reg(REG_MAX_HEIGHT, 12'd0);
               write_reg(REG_X_SPACING, 12'hF01);
            end
            2: begin
               write_reg(REG_MIN_HEIGHT, 12'd2000);
               write_reg(REG_MAX_HEIGHT, 12'd2000);
               write_reg(REG_X_SPACING, 12'hF00);
               write_reg(REG_UNUSED, 12'hFFF);
            end
            default: begin
               write_reg(REG_MIN_HEIGHT, CSRDW'($urandom_range(0, 1500)));
               write_reg(REG_MAX_HEIGHT, CSRDW'($urandom_range(2000, 4095)));
               write_reg(REG_X_SPACING, CSRDW'($urandom_range(0, 4095)));
            end
         endcase
         csr_bus.valid <= 1'b0;
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (p == 0 && i == 8)
               hold_off_req = 1'b1;
            if (p == 1 && i == 13)
               drain_points();
            send_random_anchor();
         end
      end

      drain_points();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
